>>> rtl/can_packet_deframer_crc32_assert.svh
// Assertion macros shared by the deframer RTL.
`ifndef CAN_PACKET_DEFRAMER_CRC32_ASSERT_SVH
`define CAN_PACKET_DEFRAMER_CRC32_ASSERT_SVH

`ifndef ASSERT_OFF

// Checked only while out of reset.
`define CPD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("cpd assertion failed");

// Checked at every edge, reset included.
`define CPD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("cpd assertion failed");

`else

`define CPD_ASSERT(label, clk, rst_n, prop)
`define CPD_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

>>> rtl/cpd_pkg.sv
`default_nettype none

package cpd_pkg;

    localparam int FRAME_BYTES     = 8;
    localparam int STORE_BYTES_DEF = 256;
    localparam int ID_W            = 29;
    localparam int LEN_W           = 4;
    localparam int PLEN_W          = 8;
    localparam int POS_W           = 9;   // byte count of a packet, up to 255 + 8
    localparam int CRC_W           = 32;

    localparam logic [7:0]       SYNC_LOW   = 8'h37;
    localparam logic [7:0]       SYNC_HIGH  = 8'h13;
    localparam logic [7:0]       SPARE_BYTE = 8'h00;
    localparam logic [CRC_W-1:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [CRC_W-1:0] CRC_INIT   = 32'hFFFFFFFF;

    localparam logic [ID_W-1:0]   ID_RESET   = 29'd291;
    localparam logic [PLEN_W-1:0] PLEN_RESET = 8'd8;

    typedef enum logic {
        REG_FRAME_ID,
        REG_PAYLOAD_LEN
    } t_cfg_reg;

    // write side of one byte lane
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] base;
        logic [LEN_W-1:0] count;
    } t_wr_ctl;

    // read side of one byte lane
    typedef struct packed {
        logic             en;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] held;
    } t_rd_ctl;

    // two bytes into the CRC unit per cycle
    typedef struct packed {
        logic       clear;
        logic       en0;
        logic       en1;
        logic [7:0] b0;
        logic [7:0] b1;
    } t_crc_step;

    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [7:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/cpd_ram.sv
`default_nettype none

module cpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/cpd_lane.sv
`default_nettype none

// One byte lane: owns the bank of store bytes whose offset mod 8 equals LANE.
module cpd_lane #(
    parameter int STORE_BYTES = cpd_pkg::STORE_BYTES_DEF,
    parameter int LANE        = 0
) (
    input  wire logic                                i_clk,
    input  wire cpd_pkg::t_wr_ctl                    i_wr,
    input  wire logic [8*cpd_pkg::FRAME_BYTES-1:0]   i_frame,
    input  wire cpd_pkg::t_rd_ctl                    i_rd,
    output logic [7:0]                               o_byte
);

    localparam int ROWS  = (STORE_BYTES + cpd_pkg::FRAME_BYTES - 1) / cpd_pkg::FRAME_BYTES;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

    logic [2:0]               w_idx;
    logic [cpd_pkg::POS_W-1:0] w_addr;
    logic                     w_en;
    logic [7:0]               w_byte;
    logic [cpd_pkg::POS_W-1:0] rd_addr;
    logic                     rd_ok;
    logic [7:0]               ram_q;

    // which frame byte lands in this bank
    assign w_idx  = 3'(LANE) - i_wr.base[2:0];
    assign w_addr = i_wr.base + {{(cpd_pkg::POS_W-3){1'b0}}, w_idx};
    assign w_byte = i_frame[{w_idx, 3'b000} +: 8];
    assign w_en   = i_wr.en && ({1'b0, w_idx} < i_wr.count)
                    && ({23'd0, w_addr} < 32'(STORE_BYTES));

    assign rd_addr = i_rd.pos + cpd_pkg::POS_W'(LANE);
    assign rd_ok   = (rd_addr < i_rd.held) && ({23'd0, rd_addr} < 32'(STORE_BYTES));

    cpd_ram #(
        .WIDTH (8),
        .DEPTH (ROWS),
        .AW    (ROW_W)
    ) u_bank (
        .i_clk     (i_clk),
        .i_wr_en   (w_en),
        .i_wr_addr (ROW_W'(w_addr >> 3)),
        .i_wr_data (w_byte),
        .i_rd_en   (i_rd.en),
        .i_rd_addr (ROW_W'(rd_addr >> 3)),
        .o_rd_data (ram_q)
    );

    // pos and held hold steady from read to load
    assign o_byte = rd_ok ? ram_q : 8'd0;

endmodule

`default_nettype wire

>>> rtl/cpd_crc.sv
`default_nettype none

// Running CRC-32, two bytes a cycle.
module cpd_crc (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire cpd_pkg::t_crc_step            i_step,
    output logic [cpd_pkg::CRC_W-1:0]          o_crc
);

    logic [cpd_pkg::CRC_W-1:0] r_crc;
    logic [cpd_pkg::CRC_W-1:0] crc_a;
    logic [cpd_pkg::CRC_W-1:0] crc_b;

    assign crc_a = i_step.en0 ? cpd_pkg::crc_byte(r_crc, i_step.b0) : r_crc;
    assign crc_b = i_step.en1 ? cpd_pkg::crc_byte(crc_a, i_step.b1) : crc_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_step.clear) begin
            r_crc <= cpd_pkg::CRC_INIT;
        end else begin
            r_crc <= crc_b;
        end
    end

    assign o_crc = r_crc;

endmodule

`default_nettype wire

>>> rtl/can_packet_deframer_crc32.sv
// Frame handling: a payload frame is taken in ST_IDLE, appended in ST_CRC
// (two bytes a cycle through the CRC unit), then checked in ST_CHECK; no new frame is taken until back in ST_IDLE.
// Payload leaves one word per bank read (ST_RD) and lane merge into the output
// register (ST_LOAD); the next read starts only once the word is loaded, which waits while the output is full.
// Reset: synchronous, active low; control registers to default values, header search.
// Payload banks are not cleared; no clearing pass.
`default_nettype none

`include "can_packet_deframer_crc32_assert.svh"

module can_packet_deframer_crc32 #(
    parameter int STORE_BYTES = cpd_pkg::STORE_BYTES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    // slave: frame_id[28:0], frame_len[32:29], data_0..data_7[96:33], zero pad
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [103:0]  s_tdata,
    // master: out_0..out_7[63:0], valid_bytes[67:64], packet_crc[99:68], zero pad
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [103:0]       m_tdata,
    output logic               m_tlast,
    // configuration write
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic          i_cfg_index,
    input  wire logic [28:0]   i_cfg_data
);

    localparam int NB = cpd_pkg::FRAME_BYTES;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CRC,
        ST_CHECK,
        ST_RD,
        ST_LOAD
    } t_state;

    t_state                           r_state;
    logic [cpd_pkg::ID_W-1:0]         r_cfg_id;
    logic [cpd_pkg::PLEN_W-1:0]       r_cfg_plen;
    logic                             r_in_payload;
    logic [cpd_pkg::CRC_W-1:0]        r_exp_crc;
    logic [cpd_pkg::POS_W-1:0]        r_held;
    logic [8*NB-1:0]                  r_data;
    logic [cpd_pkg::LEN_W-1:0]        r_n;
    logic [cpd_pkg::LEN_W-1:0]        r_k;
    logic [cpd_pkg::POS_W-1:0]        r_pos;
    logic                             r_out_valid;
    logic [8*NB-1:0]                  r_out_bytes;
    logic [cpd_pkg::LEN_W-1:0]        r_out_cnt;
    logic                             r_out_last;
    logic [cpd_pkg::CRC_W-1:0]        r_out_crc;

    logic [cpd_pkg::ID_W-1:0]         in_id;
    logic [cpd_pkg::LEN_W-1:0]        in_len;
    logic [cpd_pkg::LEN_W-1:0]        in_n;
    logic [8*NB-1:0]                  in_data;
    logic                             in_acc;
    logic                             is_header;
    logic [2:0]                       k1;
    logic                             crc_done;
    logic [cpd_pkg::CRC_W-1:0]        crc_now;
    logic [cpd_pkg::POS_W-1:0]        left;
    logic                             word_last;
    logic [cpd_pkg::LEN_W-1:0]        word_cnt;
    logic                             out_free;
    logic [8*NB-1:0]                  lane_bytes;
    logic                             clear_pkt;
    cpd_pkg::t_wr_ctl                 wr_ctl;
    cpd_pkg::t_rd_ctl                 rd_ctl;
    cpd_pkg::t_crc_step               crc_step;

    assign in_id   = s_tdata[28:0];
    assign in_len  = s_tdata[32:29];
    assign in_data = s_tdata[96:33];
    assign in_n    = (in_len > 4'd8) ? 4'd8 : in_len;
    assign in_acc  = s_tvalid && s_tready;

    assign is_header = (in_n == 4'd8)
                       && (in_data[7:0]   == cpd_pkg::SYNC_LOW)
                       && (in_data[15:8]  == cpd_pkg::SYNC_HIGH)
                       && (in_data[23:16] == r_cfg_plen)
                       && (in_data[31:24] == cpd_pkg::SPARE_BYTE);

    assign s_tready    = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // append: two bytes a cycle into the CRC, all bytes to the banks on the first
    assign k1       = r_k[2:0] + 3'd1;
    assign crc_done = ((r_k + 4'd2) >= r_n);

    always_comb begin
        crc_step.clear = 1'b0;
        if (in_acc && (in_id == r_cfg_id) && !r_in_payload && is_header) begin
            crc_step.clear = 1'b1;
        end
        if (clear_pkt) begin
            crc_step.clear = 1'b1;
        end
        crc_step.en0 = (r_state == ST_CRC) && (r_k < r_n);
        crc_step.en1 = (r_state == ST_CRC) && ((r_k + 4'd1) < r_n);
        crc_step.b0  = r_data[{r_k[2:0], 3'b000} +: 8];
        crc_step.b1  = r_data[{k1, 3'b000} +: 8];
    end

    cpd_crc u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (crc_step),
        .o_crc   (crc_now)
    );

    assign wr_ctl.en    = (r_state == ST_CRC) && (r_k == 4'd0);
    assign wr_ctl.base  = r_held;
    assign wr_ctl.count = r_n;

    assign rd_ctl.en   = (r_state == ST_RD);
    assign rd_ctl.pos  = r_pos;
    assign rd_ctl.held = r_held;

    for (genvar g = 0; g < NB; g++) begin : g_lane
        cpd_lane #(
            .STORE_BYTES (STORE_BYTES),
            .LANE        (g)
        ) u_lane (
            .i_clk   (i_clk),
            .i_wr    (wr_ctl),
            .i_frame (r_data),
            .i_rd    (rd_ctl),
            .o_byte  (lane_bytes[8*g +: 8])
        );
    end

    // merge stage
    assign left      = r_held - r_pos;
    assign word_last = (left <= 9'd8);
    assign word_cnt  = word_last ? left[3:0] : 4'd8;
    assign out_free  = !r_out_valid || m_tready;

    always_comb begin
        clear_pkt = 1'b0;
        unique case (r_state)
            ST_CHECK: begin
                if (r_held > {1'b0, r_cfg_plen}) begin
                    clear_pkt = 1'b1;
                end else if (r_held == {1'b0, r_cfg_plen}) begin
                    if (!((crc_now ^ cpd_pkg::CRC_INIT) == r_exp_crc)
                        || (r_held == 9'd0)) begin
                        clear_pkt = 1'b1;
                    end
                end
            end
            ST_LOAD: clear_pkt = out_free && word_last;
            ST_IDLE, ST_CRC, ST_RD: clear_pkt = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cfg_id     <= cpd_pkg::ID_RESET;
            r_cfg_plen   <= cpd_pkg::PLEN_RESET;
            r_in_payload <= 1'b0;
            r_exp_crc    <= '0;
            r_held       <= '0;
            r_k          <= '0;
            r_pos        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (cpd_pkg::t_cfg_reg'(i_cfg_index))
                    cpd_pkg::REG_FRAME_ID:    r_cfg_id   <= i_cfg_data;
                    cpd_pkg::REG_PAYLOAD_LEN: r_cfg_plen <= i_cfg_data[7:0];
                endcase
            end

            if (r_out_valid && m_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc && (in_id == r_cfg_id)) begin
                        r_data <= in_data;
                        r_n    <= in_n;
                        r_k    <= '0;
                        if (r_in_payload) begin
                            r_state <= ST_CRC;
                        end else if (is_header) begin
                            r_exp_crc    <= in_data[63:32];
                            r_in_payload <= 1'b1;
                            r_held       <= '0;
                        end
                    end
                end
                ST_CRC: begin
                    r_k <= r_k + 4'd2;
                    if (crc_done) begin
                        r_held  <= r_held + {5'd0, r_n};
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: begin
                    r_pos <= '0;
                    if (clear_pkt) begin
                        r_in_payload <= 1'b0;
                        r_held       <= '0;
                        r_state      <= ST_IDLE;
                    end else if (r_held == {1'b0, r_cfg_plen}) begin
                        r_state <= ST_RD;
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD: begin
                    r_state <= ST_LOAD;
                end
                ST_LOAD: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_bytes <= lane_bytes;
                        r_out_cnt   <= word_cnt;
                        r_out_last  <= word_last;
                        r_out_crc   <= r_exp_crc;
                        r_pos       <= r_pos + 9'd8;
                        if (word_last) begin
                            r_in_payload <= 1'b0;
                            r_held       <= '0;
                            r_state      <= ST_IDLE;
                        end else begin
                            r_state <= ST_RD;
                        end
                    end
                end
            endcase
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'd0, r_out_crc, r_out_cnt, r_out_bytes};
    assign m_tlast  = r_out_last;

    `CPD_ASSERT(a_word_from_load, i_clk, i_rst_n, $rose(r_out_valid) |-> ($past(r_state) == ST_LOAD))
    `CPD_ASSERT(a_idle_empty, i_clk, i_rst_n, (!r_in_payload) |-> (r_held == 9'd0))
    `CPD_ASSERT(a_read_in_range, i_clk, i_rst_n, (r_state == ST_RD) |-> (r_pos < r_held))
    `CPD_ASSERT(a_last_clears, i_clk, i_rst_n, ($rose(r_out_valid) && r_out_last) |-> !r_in_payload)
    `CPD_ASSERT(a_check_in_packet, i_clk, i_rst_n, (r_state == ST_CHECK) |-> r_in_payload)

endmodule

`default_nettype wire
